// ===== sv/esc_split_pkg.sv =====
// Package for the escaped delimiter splitter: sizes, register indexes,
// configuration and result types. No dependencies.
package esc_split_pkg;

    localparam int SEP_MAX    = 8;
    localparam int SHIELD_MAX = 8;
    localparam int POS_BITS   = 32;
    localparam int WIN        = SEP_MAX + SHIELD_MAX;
    localparam int WIN_IW     = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int SEP_IW     = (SEP_MAX > 1) ? $clog2(SEP_MAX) : 1;
    localparam int LEN_W      = 4;
    localparam int PAT_W      = 64;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 5;
    localparam int OUT_W      = 32;

    typedef enum logic [1:0] {
        REG_SEP_BYTES = 2'd0,
        REG_SEP_LEN   = 2'd1,
        REG_SHD_BYTES = 2'd2,
        REG_SHD_LEN   = 2'd3
    } reg_idx_t;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct packed {
        logic [PAT_W-1:0] sep_bytes;
        logic [LEN_W-1:0] sep_len;
        logic [PAT_W-1:0] shd_bytes;
        logic [LEN_W-1:0] shd_len;
    } cfg_t;

    typedef struct packed {
        logic [OUT_W-1:0] token_start;
        logic [OUT_W-1:0] token_length;
        logic             is_final;
        logic             no_split;
    } result_t;

endpackage

// ===== sv/escaped_delimiter_splitter.sv =====
// Escaped delimiter splitter: top level with input and result registers.
// Depends on esc_split_pkg, esc_split_apb and esc_split_core.
//
// Usage:
//   Bytes arrive on the byte channel (data_byte, end_of_stream) with
//   byte_valid/byte_ready. Each separator not preceded by the shield pattern
//   gives one token on the token channel (token_start, token_length,
//   is_final, no_split) with token_valid/token_ready. The last byte of a
//   stream gives the trailing token, or a no-split marker if no separator
//   was accepted; then the stream offsets restart from zero.
//   Throughput: one byte per cycle while no token waits; the separator
//   and shield windows are compared in parallel in the cycle after the
//   byte is registered. When a byte advances out of the input register,
//   its token, if any, goes into the result register and raises token_valid.
//   Stall: while a token waits, the registered byte holds and byte_ready
//   drops; one byte is still taken into the empty input register.
//   Reset: separator 0 of length 1, shielding off, all offsets zero.
//   Configure over APB (64-bit registers at 8*i) only while idle.
module escaped_delimiter_splitter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [esc_split_pkg::ADDR_W-1:0] paddr,
    input  logic [esc_split_pkg::DATA_W-1:0] pwdata,
    output logic [esc_split_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  logic                             byte_valid,
    output logic                             byte_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             end_of_stream,
    output logic                             token_valid,
    input  logic                             token_ready,
    output logic [esc_split_pkg::OUT_W-1:0]  token_start,
    output logic [esc_split_pkg::OUT_W-1:0]  token_length,
    output logic                             is_final,
    output logic                             no_split
);
    import esc_split_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       advance;
    logic       emit;
    result_t    result;
    logic       out_valid_reg;
    result_t    out_reg;

    esc_split_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esc_split_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .emit          (emit),
        .result        (result)
    );

    // registered item moves on once the result slot is free or being taken
    assign advance    = in_valid_reg && (!out_valid_reg || token_ready);
    assign byte_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
                in_valid_reg <= byte_valid;
            if (advance)
                out_valid_reg <= emit;
            else if (token_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_byte_reg <= data_byte;
            in_eos_reg  <= end_of_stream;
        end
        if (advance)
            out_reg <= result;
    end

    assign token_valid  = out_valid_reg;
    assign token_start  = out_reg.token_start;
    assign token_length = out_reg.token_length;
    assign is_final     = out_reg.is_final;
    assign no_split     = out_reg.no_split;

`ifndef ASSERT_OFF
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> (token_valid && !token_ready))
        else $error("byte_ready low without a stalled token");

    a_accept_loads_input: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_ready) |=> in_valid_reg)
        else $error("accepted item not held in input register");

    a_no_split_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && no_split) |-> (is_final && token_start == '0))
        else $error("no-split marker not final or not at offset zero");

    a_stalled_token_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && !token_ready) |=> (token_valid && $stable(token_length)))
        else $error("stalled token lost or changed");
`endif

endmodule

// ===== sv/esc_split_apb.sv =====
// APB register file of the splitter: separator and shield patterns and lengths.
// Depends on esc_split_pkg.
module esc_split_apb (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [esc_split_pkg::ADDR_W-1:0] paddr,
    input  logic [esc_split_pkg::DATA_W-1:0] pwdata,
    output logic [esc_split_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output esc_split_pkg::cfg_t              cfg
);
    import esc_split_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sep_bytes <= '0;
            cfg_reg.sep_len   <= LEN_W'(1);
            cfg_reg.shd_bytes <= '0;
            cfg_reg.shd_len   <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SEP_BYTES: cfg_reg.sep_bytes <= pwdata[PAT_W-1:0];
                REG_SEP_LEN:   cfg_reg.sep_len   <= pwdata[LEN_W-1:0];
                REG_SHD_BYTES: cfg_reg.shd_bytes <= pwdata[PAT_W-1:0];
                REG_SHD_LEN:   cfg_reg.shd_len   <= pwdata[LEN_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SEP_BYTES: prdata = DATA_W'(cfg_reg.sep_bytes);
            REG_SEP_LEN:   prdata = DATA_W'(cfg_reg.sep_len);
            REG_SHD_BYTES: prdata = DATA_W'(cfg_reg.shd_bytes);
            REG_SHD_LEN:   prdata = DATA_W'(cfg_reg.shd_len);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== sv/esc_split_core.sv =====
// Stream state and combinational separator/shield window compare of the splitter.
// Depends on esc_split_pkg.
module esc_split_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  esc_split_pkg::cfg_t    cfg,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_stream,
    output logic                   emit,
    output esc_split_pkg::result_t result
);
    import esc_split_pkg::*;

    logic [7:0] win_reg [WIN-1];
    logic [7:0] w       [WIN];
    logic [7:0] sep_b   [SEP_MAX];
    logic [7:0] shd_b   [SHIELD_MAX];

    pos_t pos_reg, pos_next;
    pos_t cur_reg, cur_next;
    pos_t na_reg, na_next;
    logic found_reg, found_next;

    logic [LEN_W-1:0] sl, kl;
    pos_t             seen, s;
    logic             sep_eq, shd_eq, hit, shielded;
    logic [LEN_W-1:0] sidx;
    logic [LEN_W:0]   widx;

    // length clamps: zero separator acts as one byte
    always_comb
    begin
        if (cfg.sep_len == '0)
            sl = LEN_W'(1);
        else if (cfg.sep_len > LEN_W'(SEP_MAX))
            sl = LEN_W'(SEP_MAX);
        else
            sl = cfg.sep_len;
        if (cfg.shd_len > LEN_W'(SHIELD_MAX))
            kl = LEN_W'(SHIELD_MAX);
        else
            kl = cfg.shd_len;
    end

    always_comb
    begin
        w[0] = data_byte;
        for (int i = 1; i < WIN; i++)
            w[i] = win_reg[i-1];
        for (int i = 0; i < SEP_MAX; i++)
            sep_b[i] = cfg.sep_bytes[8*i +: 8];
        for (int i = 0; i < SHIELD_MAX; i++)
            shd_b[i] = cfg.shd_bytes[8*i +: 8];
    end

    // window compare: w[j] holds the byte j places back from the newest
    always_comb
    begin
        sep_eq = 1'b1;
        sidx   = '0;
        for (int j = 0; j < SEP_MAX; j++)
        begin
            sidx = sl - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < sl && w[j] != sep_b[sidx[SEP_IW-1:0]])
                sep_eq = 1'b0;
        end
        shd_eq = 1'b1;
        widx   = '0;
        for (int i = 0; i < SHIELD_MAX; i++)
        begin
            widx = {1'b0, sl} + {1'b0, kl} - (LEN_W+1)'(1) - (LEN_W+1)'(i);
            if (LEN_W'(i) < kl && w[widx[WIN_IW-1:0]] != shd_b[i])
                shd_eq = 1'b0;
        end
    end

    always_comb
    begin
        seen     = (pos_reg != '1) ? pos_reg + POS_BITS'(1) : pos_reg;
        s        = seen - POS_BITS'(sl);
        hit      = (seen >= POS_BITS'(sl)) && (s >= na_reg) && sep_eq;
        shielded = (kl != '0) && (s >= POS_BITS'(kl)) && shd_eq;

        emit       = 1'b0;
        result     = '0;
        pos_next   = seen;
        cur_next   = cur_reg;
        na_next    = hit ? seen : na_reg;
        found_next = found_reg;

        if (hit && !shielded)
        begin
            emit                = 1'b1;
            result.token_start  = OUT_W'(cur_reg);
            result.token_length = (s >= cur_reg) ? OUT_W'(s - cur_reg) : '0;
            result.is_final     = end_of_stream;
            found_next          = 1'b1;
            cur_next            = seen;
        end

        if (end_of_stream)
        begin
            if (!emit)
            begin
                if (found_reg)
                begin
                    if (cur_reg < seen)
                    begin
                        emit                = 1'b1;
                        result.token_start  = OUT_W'(cur_reg);
                        result.token_length = OUT_W'(seen - cur_reg);
                        result.is_final     = 1'b1;
                    end
                end
                else
                begin
                    emit                = 1'b1;
                    result.token_length = OUT_W'(seen);
                    result.is_final     = 1'b1;
                    result.no_split     = 1'b1;
                end
            end
            pos_next   = '0;
            cur_next   = '0;
            na_next    = '0;
            found_next = 1'b0;
        end
    end

    // history bytes are only read inside the current stream, so no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            win_reg[0] <= data_byte;
            for (int i = 1; i < WIN-1; i++)
                win_reg[i] <= win_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            cur_reg   <= '0;
            na_reg    <= '0;
            found_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            cur_reg   <= cur_next;
            na_reg    <= na_next;
            found_reg <= found_next;
        end
    end

endmodule

// ===== dv/tb_escaped_delimiter_splitter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for escaped_delimiter_splitter: directed table, then random streams
// under random separator/shield settings. Depends on esc_split_pkg and the splitter RTL.
module tb_escaped_delimiter_splitter;
    import esc_split_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 110;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_idx_t    reg_sel;
        logic [63:0] value;
        logic [7:0]  data;
        logic        eos;
        logic        pinned;
        result_t     want;
    } stim_row_t;

    localparam result_t NO_TOKEN = '0;
    localparam int      NROWS    = 34;

    // pinned rows carry a hand-written token; the rest go through the predictor
    localparam stim_row_t DIRECTED_ROWS [NROWS] = '{
        // reset settings: separator 8'h00 of one byte, no shield
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b1, 1'b1, '{32'd0, 32'd1, 1'b1, 1'b1}},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h00, 1'b1, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h00, 1'b0, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h00, 1'b0, 1'b1, '{32'd1, 32'd0, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h41, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b1, 1'b1, '{32'd2, 32'd2, 1'b1, 1'b0}},
        // two-byte separator, shield 8'h00 that the cleared window would match at start
        '{ROW_CFG,  REG_SEP_BYTES, 64'h4241, 8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_CFG,  REG_SEP_LEN,   64'd2,    8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_CFG,  REG_SHD_BYTES, 64'd0,    8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_CFG,  REG_SHD_LEN,   64'd1,    8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h41, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h42, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h41, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h42, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h78, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h41, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h42, 1'b1, 1'b0, NO_TOKEN},
        // widest patterns, length registers above range
        '{ROW_CFG,  REG_SEP_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_CFG,  REG_SEP_LEN,   64'hF, 8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_CFG,  REG_SHD_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_CFG,  REG_SHD_LEN,   64'hF, 8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b1, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
        // separator length zero acts as one byte (8'hFF), shield off
        '{ROW_CFG,  REG_SEP_LEN,   64'd0, 8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_CFG,  REG_SHD_LEN,   64'd0, 8'h00, 1'b0, 1'b0, NO_TOKEN},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b1, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
        '{ROW_BYTE, REG_SEP_BYTES, 64'd0, 8'h00, 1'b1, 1'b1, '{32'd0, 32'd1, 1'b1, 1'b1}}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                byte_valid;
    logic                byte_ready;
    logic [7:0]          data_byte;
    logic                end_of_stream;
    logic                token_valid;
    logic                token_ready;
    logic [OUT_W-1:0]    token_start;
    logic [OUT_W-1:0]    token_length;
    logic                is_final;
    logic                no_split;

    escaped_delimiter_splitter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .token_valid   (token_valid),
        .token_ready   (token_ready),
        .token_start   (token_start),
        .token_length  (token_length),
        .is_final      (is_final),
        .no_split      (no_split)
    );

    // predictor copy of registers and stream state
    cfg_t        split_cfg;
    logic [7:0]  win_bytes [WIN];
    pos_t        next_pos;
    pos_t        tok_start;
    pos_t        match_floor;
    bit          any_split;

    result_t     token_queue [$];
    logic [7:0]  alpha [4];
    int unsigned fails;
    int unsigned cycle_count;
    bit          quiet;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int sep_span();
        if (split_cfg.sep_len == 0)
            return 1;
        if (split_cfg.sep_len > SEP_MAX)
            return SEP_MAX;
        return int'(split_cfg.sep_len);
    endfunction

    function automatic int shield_span();
        if (split_cfg.shd_len > SHIELD_MAX)
            return SHIELD_MAX;
        return int'(split_cfg.shd_len);
    endfunction

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic stream_clear();
        for (int i = 0; i < WIN; i++)
            win_bytes[i] = 8'h00;
        next_pos    = '0;
        tok_start   = '0;
        match_floor = '0;
        any_split   = 1'b0;
    endtask

    task automatic split_predict(input logic [7:0] b, input logic last,
                                 output bit got, output result_t tok);
        pos_t seen;
        pos_t s;
        int   sl;
        int   kl;
        bit   hit;
        bit   shielded;
        got      = 1'b0;
        tok      = '0;
        sl       = sep_span();
        kl       = shield_span();
        seen     = (next_pos != '1) ? next_pos + 1'b1 : next_pos;
        for (int i = WIN - 1; i > 0; i--)
            win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = b;
        if (seen >= pos_t'(sl))
        begin
            s   = seen - pos_t'(sl);
            hit = (s >= match_floor);
            for (int i = 0; i < sl; i++)
                if (win_bytes[sl-1-i] != split_cfg.sep_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                shielded    = 1'b0;
                match_floor = seen;
                // a separator too close to the stream start is never shielded
                if (kl > 0 && s >= pos_t'(kl))
                begin
                    shielded = 1'b1;
                    for (int i = 0; i < kl; i++)
                        if (win_bytes[sl+kl-1-i] != split_cfg.shd_bytes[8*i +: 8])
                            shielded = 1'b0;
                end
                if (!shielded)
                begin
                    tok.token_start  = tok_start;
                    tok.token_length = (s >= tok_start) ? s - tok_start : '0;
                    tok.is_final     = last;
                    tok.no_split     = 1'b0;
                    got              = 1'b1;
                    any_split        = 1'b1;
                    tok_start        = seen;
                end
            end
        end
        if (last)
        begin
            if (!got)
            begin
                if (!any_split)
                begin
                    tok = '{32'd0, seen, 1'b1, 1'b1};
                    got = 1'b1;
                end
                else if (tok_start < seen)
                begin
                    tok = '{tok_start, seen - tok_start, 1'b1, 1'b0};
                    got = 1'b1;
                end
            end
            stream_clear();
        end
        else
            next_pos = seen;
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [63:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_SEP_BYTES: split_cfg.sep_bytes = v;
            REG_SEP_LEN:   split_cfg.sep_len   = v[LEN_W-1:0];
            REG_SHD_BYTES: split_cfg.shd_bytes = v;
            REG_SHD_LEN:   split_cfg.shd_len   = v[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] d, input logic eos,
                             input bit pinned, input result_t want);
        int unsigned gap;
        bit          got;
        result_t     tok;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid    <= 1'b1;
        data_byte     <= d;
        end_of_stream <= eos;
        do @(posedge clk); while (!byte_ready);
        split_predict(d, eos, got, tok);
        if (pinned)
            token_queue.push_back(want);
        else if (got)
            token_queue.push_back(tok);
    endtask

    // valid low, all tokens back, then a wait for a byte still in flight
    task automatic drain();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one stream of separator, shield, partial-separator and noise pieces
    task automatic random_stream(output int unsigned count);
        logic [7:0]  bytes_q [$];
        int unsigned pieces;
        int unsigned cut;
        int          sl;
        int          kl;
        sl     = sep_span();
        kl     = shield_span();
        pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 8);
        repeat (pieces)
        begin
            case ($urandom_range(0, 9))
                0, 1: bytes_q.push_back(alpha[$urandom_range(0, 3)]);
                2, 3, 4:
                    for (int i = 0; i < sl; i++)
                        bytes_q.push_back(split_cfg.sep_bytes[8*i +: 8]);
                5, 6:
                begin
                    for (int i = 0; i < kl; i++)
                        bytes_q.push_back(split_cfg.shd_bytes[8*i +: 8]);
                    for (int i = 0; i < sl; i++)
                        bytes_q.push_back(split_cfg.sep_bytes[8*i +: 8]);
                end
                7:
                    for (int i = 0; i < kl; i++)
                        bytes_q.push_back(split_cfg.shd_bytes[8*i +: 8]);
                8:
                begin
                    cut = $urandom_range(0, sl - 1);
                    for (int i = 0; i < int'(cut); i++)
                        bytes_q.push_back(split_cfg.sep_bytes[8*i +: 8]);
                end
                default: bytes_q.push_back(8'($urandom));
            endcase
        end
        if (bytes_q.size() == 0)
            bytes_q.push_back(8'($urandom));
        for (int i = 0; i < bytes_q.size(); i++)
            send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, NO_TOKEN);
        count = bytes_q.size();
    endtask

    function automatic logic [63:0] random_pattern();
        logic [63:0] p;
        p = '0;
        if ($urandom_range(0, 4) == 0)
            p = {$urandom, $urandom};
        else
            for (int i = 0; i < 8; i++)
                p[8*i +: 8] = alpha[$urandom_range(0, 3)];
        return p;
    endfunction

    // token sink: random holds, plus one long hold on request
    initial
    begin : token_sink
        int unsigned idle_left;
        bit          held;
        idle_left   = 0;
        held        = 1'b0;
        token_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                token_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            if (idle_left > 0)
            begin
                idle_left--;
                token_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                idle_left   = pick_gap() - 1;
                token_ready <= 1'b0;
            end
            else
                token_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : token_check
        result_t want;
        if (rst_n && token_valid && token_ready)
        begin
            if (token_queue.size() == 0)
            begin
                $error("unexpected token: start %0d length %0d final %0b no_split %0b",
                       token_start, token_length, is_final, no_split);
                fails++;
            end
            else
            begin
                want = token_queue.pop_front();
                if (token_start !== want.token_start)
                begin
                    $error("token_start: expected %0d, got %0d", want.token_start, token_start);
                    fails++;
                end
                if (token_length !== want.token_length)
                begin
                    $error("token_length: expected %0d, got %0d",
                           want.token_length, token_length);
                    fails++;
                end
                if (is_final !== want.is_final)
                begin
                    $error("is_final: expected %0d, got %0d", want.is_final, is_final);
                    fails++;
                end
                if (no_split !== want.no_split)
                begin
                    $error("no_split: expected %0d, got %0d", want.no_split, no_split);
                    fails++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned phase_items;
        int unsigned n;
        logic [3:0]  sep_len_w;
        logic [3:0]  shd_len_w;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        byte_valid    = 1'b0;
        data_byte     = 8'h00;
        end_of_stream = 1'b0;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        split_cfg     = '{64'd0, 4'd1, 64'd0, 4'd0};
        stream_clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NROWS; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
            begin
                drain();
                apb_write(DIRECTED_ROWS[r].reg_sel, DIRECTED_ROWS[r].value);
            end
            else
                send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].eos,
                          DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            alpha[0] = 8'h00;
            alpha[1] = 8'hFF;
            alpha[2] = 8'($urandom);
            alpha[3] = 8'($urandom);
            case ($urandom_range(0, 9))
                0:       sep_len_w = 4'd0;
                1:       sep_len_w = 4'hF;
                2:       sep_len_w = 4'(SEP_MAX);
                default: sep_len_w = 4'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: shd_len_w = 4'd0;
                3:       shd_len_w = 4'(SHIELD_MAX);
                4:       shd_len_w = 4'hF;
                default: shd_len_w = 4'($urandom_range(1, 3));
            endcase
            // short separator, no shield: tokens come fast while the sink holds off
            if (ph == 2)
            begin
                sep_len_w = 4'd1;
                shd_len_w = 4'd0;
            end
            drain();
            apb_write(REG_SEP_BYTES, random_pattern());
            apb_write(REG_SEP_LEN, 64'(sep_len_w));
            apb_write(REG_SHD_BYTES, random_pattern());
            apb_write(REG_SHD_LEN, 64'(shd_len_w));
            quiet = (ph == 2 || ph == 5);
            if (ph == 2)
                hold_request = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                random_stream(n);
                phase_items += n;
            end
        end

        quiet = 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/esc_split_pkg.sv
sv/esc_split_apb.sv
sv/esc_split_core.sv
sv/escaped_delimiter_splitter.sv
dv/tb_escaped_delimiter_splitter.sv
